// File: sv/srp_pkg.sv
// Shared types and constants for the SOCKS5 reply parser.
// Holds the status codes, protocol byte values and the result record type.
// No dependencies.
`timescale 1ns / 1ps

package srp_pkg;

  localparam int BYTE_W  = 8;
  localparam int COUNT_W = 9;
  localparam int ADDR_W  = 32;
  localparam int PORT_W  = 16;
  localparam int STAT_W  = 3;

  // Result status codes.
  localparam logic [STAT_W-1:0] ST_OK        = 3'd0;
  localparam logic [STAT_W-1:0] ST_BAD_VER   = 3'd1;
  localparam logic [STAT_W-1:0] ST_BAD_AUTH  = 3'd2;
  localparam logic [STAT_W-1:0] ST_SRV_ERR   = 3'd3;
  localparam logic [STAT_W-1:0] ST_BAD_ATYPE = 3'd4;

  // Protocol byte values.
  localparam logic [BYTE_W-1:0] SOCKS_VER    = 8'h05;
  localparam logic [BYTE_W-1:0] METHOD_NOAUTH = 8'h00;
  localparam logic [BYTE_W-1:0] REP_SUCCESS  = 8'h00;
  localparam logic [BYTE_W-1:0] ATYP_IPV4    = 8'h01;
  localparam logic [BYTE_W-1:0] ATYP_DOMAIN  = 8'h03;
  localparam logic [BYTE_W-1:0] ATYP_IPV6    = 8'h04;

  // Byte counts at which an address tail (address plus port) is complete.
  localparam logic [COUNT_W-1:0] IPV4_ADDR_BYTES = 9'd4;
  localparam logic [COUNT_W-1:0] IPV4_TAIL_BYTES = 9'd6;
  localparam logic [COUNT_W-1:0] IPV6_TAIL_BYTES = 9'd18;
  localparam logic [COUNT_W-1:0] PORT_BYTES      = 9'd2;

  typedef struct packed {
    logic [STAT_W-1:0] status;
    logic [BYTE_W-1:0] reply_code;
    logic [BYTE_W-1:0] address_kind;
    logic [ADDR_W-1:0] relay_address;
    logic [PORT_W-1:0] relay_port;
  } srp_res_t;

endpackage

// File: sv/srp_in_stage.sv
// Input register of the SOCKS5 reply parser.
// Captures one received byte per transfer; uses srp_pkg for widths.
`timescale 1ns / 1ps

module srp_in_stage (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic [srp_pkg::BYTE_W-1:0] in_byte,
  input  logic                      take,
  output logic                      s_valid,
  output logic [srp_pkg::BYTE_W-1:0] s_byte
);

  logic                       valid_r;
  logic                       valid_nxt;
  logic [srp_pkg::BYTE_W-1:0] byte_r;

  // The held byte leaves when the parser takes it, so a new one may enter the same cycle.
  assign in_ready  = !valid_r || take;
  assign valid_nxt = (in_valid && in_ready) ? 1'b1 : (take ? 1'b0 : valid_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      byte_r <= in_byte;
    end
  end

  assign s_valid = valid_r;
  assign s_byte  = byte_r;

endmodule

// File: sv/srp_core.sv
// Parse state machine of the SOCKS5 reply parser; uses srp_pkg. Raises a result
// on completion or error; consumes one byte per cycle unless that result must wait.
`timescale 1ns / 1ps

module srp_core (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       method_en,
  input  logic                       byte_valid,
  input  logic [srp_pkg::BYTE_W-1:0] rx_byte,
  input  logic                       out_free,
  output logic                       take,
  output logic                       res_valid,
  output srp_pkg::srp_res_t          res
);

  localparam logic [3:0] PH_START  = 4'd0;
  localparam logic [3:0] PH_METHOD = 4'd1;
  localparam logic [3:0] PH_HVER   = 4'd2;
  localparam logic [3:0] PH_HCODE  = 4'd3;
  localparam logic [3:0] PH_HRSV   = 4'd4;
  localparam logic [3:0] PH_HKIND  = 4'd5;
  localparam logic [3:0] PH_V4     = 4'd6;
  localparam logic [3:0] PH_DLEN   = 4'd7;
  localparam logic [3:0] PH_DOM    = 4'd8;
  localparam logic [3:0] PH_V6     = 4'd9;

  logic [3:0]                    phase_r, phase_nxt;
  logic [srp_pkg::COUNT_W-1:0]   count_r, count_nxt;
  logic [srp_pkg::BYTE_W-1:0]    dlen_r, dlen_nxt;
  logic [srp_pkg::BYTE_W-1:0]    kind_r, kind_nxt;
  logic [srp_pkg::BYTE_W-1:0]    code_r, code_nxt;
  logic [srp_pkg::ADDR_W-1:0]    addr_r, addr_nxt;
  logic [srp_pkg::PORT_W-1:0]    port_r, port_nxt;
  logic [srp_pkg::COUNT_W-1:0]   cnt_inc;
  logic [srp_pkg::COUNT_W-1:0]   dom_end;
  logic                          emit;
  logic                          go;

  assign cnt_inc = count_r + 9'd1;
  assign dom_end = {1'b0, dlen_r} + srp_pkg::PORT_BYTES;

  always_comb begin
    phase_nxt = phase_r;
    count_nxt = count_r;
    dlen_nxt  = dlen_r;
    kind_nxt  = kind_r;
    code_nxt  = code_r;
    addr_nxt  = addr_r;
    port_nxt  = port_r;
    emit      = 1'b0;
    res.status        = srp_pkg::ST_OK;
    res.reply_code    = code_r;
    res.address_kind  = kind_r;
    res.relay_address = '0;
    res.relay_port    = '0;

    unique case (phase_r)
      PH_METHOD: begin
        if (rx_byte != srp_pkg::METHOD_NOAUTH) begin
          emit       = 1'b1;
          res.status = srp_pkg::ST_BAD_AUTH;
        end else begin
          phase_nxt = PH_HVER;
        end
      end
      PH_HVER: begin
        if (rx_byte != srp_pkg::SOCKS_VER) begin
          emit       = 1'b1;
          res.status = srp_pkg::ST_BAD_VER;
        end else begin
          phase_nxt = PH_HCODE;
        end
      end
      PH_HCODE: begin
        code_nxt       = rx_byte;
        res.reply_code = rx_byte;
        if (rx_byte != srp_pkg::REP_SUCCESS) begin
          emit       = 1'b1;
          res.status = srp_pkg::ST_SRV_ERR;
        end else begin
          phase_nxt = PH_HRSV;
        end
      end
      PH_HRSV: begin
        phase_nxt = PH_HKIND;
      end
      PH_HKIND: begin
        kind_nxt         = rx_byte;
        res.address_kind = rx_byte;
        count_nxt        = '0;
        if (rx_byte == srp_pkg::ATYP_IPV4) begin
          phase_nxt = PH_V4;
        end else if (rx_byte == srp_pkg::ATYP_DOMAIN) begin
          phase_nxt = PH_DLEN;
        end else if (rx_byte == srp_pkg::ATYP_IPV6) begin
          phase_nxt = PH_V6;
        end else begin
          emit       = 1'b1;
          res.status = srp_pkg::ST_BAD_ATYPE;
        end
      end
      PH_DLEN: begin
        dlen_nxt  = rx_byte;
        count_nxt = '0;
        phase_nxt = PH_DOM;
      end
      PH_V4, PH_DOM, PH_V6: begin
        // The port shifter sees every tail byte; only the last two survive.
        count_nxt      = cnt_inc;
        port_nxt       = {port_r[srp_pkg::PORT_W-srp_pkg::BYTE_W-1:0], rx_byte};
        res.relay_port = port_nxt;
        if (phase_r == PH_V4) begin
          if (cnt_inc <= srp_pkg::IPV4_ADDR_BYTES) begin
            addr_nxt = {addr_r[srp_pkg::ADDR_W-srp_pkg::BYTE_W-1:0], rx_byte};
          end
          res.relay_address = addr_nxt;
          emit = (cnt_inc >= srp_pkg::IPV4_TAIL_BYTES);
        end else if (phase_r == PH_DOM) begin
          emit = (cnt_inc >= dom_end);
        end else begin
          emit = (cnt_inc >= srp_pkg::IPV6_TAIL_BYTES);
        end
      end
      default: begin
        // Message start; a phase code with no meaning lands here as well.
        if (rx_byte != srp_pkg::SOCKS_VER) begin
          emit       = 1'b1;
          res.status = srp_pkg::ST_BAD_VER;
        end else if (method_en) begin
          phase_nxt = PH_METHOD;
        end else begin
          phase_nxt = PH_HCODE;
        end
      end
    endcase

    // Any result ends the message and clears the context.
    if (emit) begin
      phase_nxt = PH_START;
      count_nxt = '0;
      dlen_nxt  = '0;
      kind_nxt  = '0;
      code_nxt  = '0;
      addr_nxt  = '0;
      port_nxt  = '0;
    end
  end

  // A byte that yields no result never needs the output slot.
  assign go        = byte_valid && (out_free || !emit);
  assign take      = go;
  assign res_valid = go && emit;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_START;
      count_r <= '0;
      dlen_r  <= '0;
      kind_r  <= '0;
      code_r  <= '0;
      addr_r  <= '0;
      port_r  <= '0;
    end else if (go) begin
      phase_r <= phase_nxt;
      count_r <= count_nxt;
      dlen_r  <= dlen_nxt;
      kind_r  <= kind_nxt;
      code_r  <= code_nxt;
      addr_r  <= addr_nxt;
      port_r  <= port_nxt;
    end
  end

  a_restart_after_result: assert property (@(posedge clk) disable iff (!rst_n)
    res_valid |=> (phase_r == PH_START) && (count_r == '0) && (addr_r == '0))
    else $error("parser context not cleared after a result");

  a_error_zero_fields: assert property (@(posedge clk) disable iff (!rst_n)
    res_valid && (res.status != srp_pkg::ST_OK) |->
      (res.relay_address == '0) && (res.relay_port == '0))
    else $error("error result carries address or port");

  a_domain_kind: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == PH_DOM) || (phase_r == PH_DLEN) |-> kind_r == srp_pkg::ATYP_DOMAIN)
    else $error("domain phase without domain address type");

  a_tail_code_ok: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == PH_V4) || (phase_r == PH_V6) || (phase_r == PH_DOM) |->
      code_r == srp_pkg::REP_SUCCESS)
    else $error("address tail parsed after a failing reply code");

endmodule

// File: sv/srp_out_stage.sv
// Result register of the SOCKS5 reply parser.
// Holds one finished result until the receiver takes it; uses srp_pkg for the record type.
`timescale 1ns / 1ps

module srp_out_stage (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              load,
  input  srp_pkg::srp_res_t load_res,
  output logic              free,
  output logic              out_valid,
  input  logic              out_ready,
  output srp_pkg::srp_res_t out_res
);

  logic              valid_r;
  logic              valid_nxt;
  srp_pkg::srp_res_t res_r;

  assign free      = !valid_r || out_ready;
  assign valid_nxt = load ? 1'b1 : (out_ready ? 1'b0 : valid_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      res_r <= load_res;
    end
  end

  assign out_valid = valid_r;
  assign out_res   = res_r;

endmodule

// File: sv/socks5_reply_parser.sv
// Top level of the SOCKS5 reply parser.
// Depends on srp_pkg, srp_in_stage, srp_core and srp_out_stage.
`timescale 1ns / 1ps

// Usage overview.
// The input channel carries the bytes a SOCKS5 client receives from its proxy,
// one byte per transfer, in arrival order. The parser walks the optional method
// selection reply, the reply header and the bound address with its port.
// A complete reply, or the first check that fails, produces one transfer on the
// output channel with the status, reply code, address type, IPv4 relay address
// and relay port; parsing then starts over with the next byte.
// A transferred byte waits in the input register until the parser consumes it; a
// byte that ends a reply loads its result into the result register, which then
// offers it on the output channel.
// Throughput is one byte per cycle unless a result is held up by the receiver, set
// by the parse step between the input register and the result register.
// When the receiver stalls with a result waiting, bytes that produce no result
// still flow; a byte that would produce a result waits in the input register,
// and in_ready drops once that register cannot drain.
// Reset (synchronous, active low) empties both registers, returns the parser to
// message start and sets cfg_wr_data's register, the method phase enable, to 1.
// The enable must be written with cfg_wr_en while idle; the block does not check.

module socks5_reply_parser (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_rx_byte,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [2:0]  out_status,
  output logic [7:0]  out_reply_code,
  output logic [7:0]  out_address_kind,
  output logic [31:0] out_relay_address,
  output logic [15:0] out_relay_port,
  input  logic        cfg_wr_en,
  input  logic        cfg_wr_data
);

  logic              method_en_r;
  logic              s_valid;
  logic [7:0]        s_byte;
  logic              take;
  logic              out_free;
  logic              res_valid;
  srp_pkg::srp_res_t res;
  srp_pkg::srp_res_t out_res;

  // Method phase enable; sampled by the parser only at message start.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      method_en_r <= 1'b1;
    end else if (cfg_wr_en) begin
      method_en_r <= cfg_wr_data;
    end
  end

  srp_in_stage u_in (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_byte  (in_rx_byte),
    .take     (take),
    .s_valid  (s_valid),
    .s_byte   (s_byte)
  );

  srp_core u_core (
    .clk        (clk),
    .rst_n      (rst_n),
    .method_en  (method_en_r),
    .byte_valid (s_valid),
    .rx_byte    (s_byte),
    .out_free   (out_free),
    .take       (take),
    .res_valid  (res_valid),
    .res        (res)
  );

  srp_out_stage u_out (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (res_valid),
    .load_res  (res),
    .free      (out_free),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_res   (out_res)
  );

  assign out_status        = out_res.status;
  assign out_reply_code    = out_res.reply_code;
  assign out_address_kind  = out_res.address_kind;
  assign out_relay_address = out_res.relay_address;
  assign out_relay_port    = out_res.relay_port;

endmodule

// File: test/tb.sv
// Self-checking testbench for the SOCKS5 reply parser (socks5_reply_parser).
// Holds a scoreboard class with its own parse predictor plus the byte, config and result drivers.
// Depends on srp_pkg and the parser RTL.
`timescale 1ns / 1ps

module tb;

  localparam int LONG_HOLD    = 300;
  localparam int PHASE_BYTES  = 170;
  localparam int SETTLE       = 4;
  localparam int CYCLE_LIMIT  = 200000;

  // Where the predictor stands inside the current reply.
  typedef enum logic [3:0] {
    AT_START,
    AT_METHOD,
    AT_HDR_VER,
    AT_HDR_CODE,
    AT_HDR_RSV,
    AT_HDR_KIND,
    AT_IPV4,
    AT_DOM_LEN,
    AT_DOMAIN,
    AT_IPV6
  } parse_pos_t;

  // Tracks the parse state and keeps the replies that are still due from the block.
  class socks_reply_board_t;
    logic                        method_en;
    parse_pos_t                  pos;
    logic [srp_pkg::COUNT_W-1:0] tail_count;
    logic [srp_pkg::BYTE_W-1:0]  dom_len;
    logic [srp_pkg::BYTE_W-1:0]  kind;
    logic [srp_pkg::BYTE_W-1:0]  code;
    logic [srp_pkg::ADDR_W-1:0]  addr_acc;
    logic [srp_pkg::PORT_W-1:0]  port_acc;
    srp_pkg::srp_res_t           awaited_replies[$];
    int                          errors;
    int                          replies_checked;
    int                          ok_replies;

    function new();
      method_en = 1'b1;
      errors = 0;
      replies_checked = 0;
      ok_replies = 0;
      restart();
    endfunction

    function void restart();
      pos = AT_START;
      tail_count = '0;
      dom_len = '0;
      kind = '0;
      code = '0;
      addr_acc = '0;
      port_acc = '0;
    endfunction

    function void finish_reply(logic [srp_pkg::STAT_W-1:0] st,
                               logic [srp_pkg::ADDR_W-1:0] a,
                               logic [srp_pkg::PORT_W-1:0] p);
      srp_pkg::srp_res_t r;
      r.status = st;
      r.reply_code = code;
      r.address_kind = kind;
      r.relay_address = a;
      r.relay_port = p;
      awaited_replies.push_back(r);
      restart();
    endfunction

    function int awaited();
      return awaited_replies.size();
    endfunction

    // Advances the parse by one accepted byte and queues a reply if one is due.
    function void note_byte(logic [srp_pkg::BYTE_W-1:0] b);
      logic [srp_pkg::COUNT_W-1:0] cnt;
      case (pos)
        AT_METHOD: begin
          if (b != srp_pkg::METHOD_NOAUTH) finish_reply(srp_pkg::ST_BAD_AUTH, '0, '0);
          else pos = AT_HDR_VER;
        end
        AT_HDR_VER: begin
          if (b != srp_pkg::SOCKS_VER) finish_reply(srp_pkg::ST_BAD_VER, '0, '0);
          else pos = AT_HDR_CODE;
        end
        AT_HDR_CODE: begin
          code = b;
          if (b != srp_pkg::REP_SUCCESS) finish_reply(srp_pkg::ST_SRV_ERR, '0, '0);
          else pos = AT_HDR_RSV;
        end
        AT_HDR_RSV: pos = AT_HDR_KIND;
        AT_HDR_KIND: begin
          kind = b;
          tail_count = '0;
          if (b == srp_pkg::ATYP_IPV4) pos = AT_IPV4;
          else if (b == srp_pkg::ATYP_DOMAIN) pos = AT_DOM_LEN;
          else if (b == srp_pkg::ATYP_IPV6) pos = AT_IPV6;
          else finish_reply(srp_pkg::ST_BAD_ATYPE, '0, '0);
        end
        AT_DOM_LEN: begin
          dom_len = b;
          tail_count = '0;
          pos = AT_DOMAIN;
        end
        AT_IPV4, AT_DOMAIN, AT_IPV6: begin
          cnt = tail_count + 1'b1;
          tail_count = cnt;
          port_acc = {port_acc[7:0], b};
          if (pos == AT_IPV4) begin
            if (cnt <= srp_pkg::IPV4_ADDR_BYTES) addr_acc = {addr_acc[23:0], b};
            if (cnt >= srp_pkg::IPV4_TAIL_BYTES) begin
              finish_reply(srp_pkg::ST_OK, addr_acc, port_acc);
            end
          end else if (pos == AT_DOMAIN) begin
            if (cnt >= {1'b0, dom_len} + srp_pkg::PORT_BYTES) begin
              finish_reply(srp_pkg::ST_OK, '0, port_acc);
            end
          end else begin
            if (cnt >= srp_pkg::IPV6_TAIL_BYTES) finish_reply(srp_pkg::ST_OK, '0, port_acc);
          end
        end
        default: begin
          // Message start: the enable decides what the version byte opens.
          if (b != srp_pkg::SOCKS_VER) finish_reply(srp_pkg::ST_BAD_VER, '0, '0);
          else pos = method_en ? AT_METHOD : AT_HDR_CODE;
        end
      endcase
    endfunction

    function void check_reply(srp_pkg::srp_res_t got);
      srp_pkg::srp_res_t want;
      if (awaited_replies.size() == 0) begin
        $error("unexpected result: status %0d port %h", got.status, got.relay_port);
        errors++;
        return;
      end
      want = awaited_replies.pop_front();
      replies_checked++;
      if (want.status == srp_pkg::ST_OK) ok_replies++;
      if (got.status !== want.status) begin
        $error("status: expected %0d, got %0d", want.status, got.status);
        errors++;
      end
      if (got.reply_code !== want.reply_code) begin
        $error("reply_code: expected %h, got %h", want.reply_code, got.reply_code);
        errors++;
      end
      if (got.address_kind !== want.address_kind) begin
        $error("address_kind: expected %h, got %h", want.address_kind, got.address_kind);
        errors++;
      end
      if (got.relay_address !== want.relay_address) begin
        $error("relay_address: expected %h, got %h", want.relay_address, got.relay_address);
        errors++;
      end
      if (got.relay_port !== want.relay_port) begin
        $error("relay_port: expected %h, got %h", want.relay_port, got.relay_port);
        errors++;
      end
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst_n;
  logic        in_valid;
  logic        in_ready;
  logic [7:0]  in_rx_byte;
  logic        out_valid;
  logic        out_ready;
  logic [2:0]  out_status;
  logic [7:0]  out_reply_code;
  logic [7:0]  out_address_kind;
  logic [31:0] out_relay_address;
  logic [15:0] out_relay_port;
  logic        cfg_wr_en;
  logic        cfg_wr_data;

  socks_reply_board_t board = new();
  logic [7:0]         plan[$];
  int                 bytes_sent = 0;
  int                 cycles = 0;
  bit                 hold_req = 1'b0;

  socks5_reply_parser u_top (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_rx_byte       (in_rx_byte),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_status       (out_status),
    .out_reply_code   (out_reply_code),
    .out_address_kind (out_address_kind),
    .out_relay_address(out_relay_address),
    .out_relay_port   (out_relay_port),
    .cfg_wr_en        (cfg_wr_en),
    .cfg_wr_data      (cfg_wr_data)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // The watchdog ends a run that hangs on a handshake.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("tb: FAIL");
      $finish;
    end
  end

  // Every result transfer is checked against the oldest reply the predictor queued.
  // Values read here are the ones from before the edge, so the sample is race free.
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      board.check_reply({out_status, out_reply_code, out_address_kind,
                         out_relay_address, out_relay_port});
    end
  end

  // The receiver switches between stretches that are always ready, lightly stalled and
  // heavily stalled. On request it holds off for a long stretch so that both internal
  // registers fill up and in_ready has to drop.
  initial begin : receiver
    int seg_left;
    int stall_pct;
    out_ready <= 1'b0;
    seg_left = 0;
    stall_pct = 0;
    forever begin
      @(posedge clk);
      if (seg_left == 0) begin
        seg_left = $urandom_range(20, 80);
        case ($urandom_range(0, 2))
          0: stall_pct = 0;
          1: stall_pct = 30;
          default: stall_pct = 75;
        endcase
      end
      seg_left--;
      if (hold_req) begin
        hold_req = 1'b0;
        out_ready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
      end else begin
        out_ready <= ($urandom_range(0, 99) >= stall_pct);
      end
    end
  end

  function automatic void put(logic [7:0] b);
    plan.push_back(b);
  endfunction

  function automatic logic [7:0] not_version();
    logic [7:0] b;
    b = 8'($urandom);
    if (b == srp_pkg::SOCKS_VER) b = 8'h00;
    return b;
  endfunction

  function automatic void put_random(int n);
    repeat (n) put(8'($urandom));
  endfunction

  // Everything up to and including the address type byte of a reply.
  function automatic void put_header(bit method_en, logic [7:0] kind_byte);
    if (method_en) begin
      put(srp_pkg::SOCKS_VER);
      put(srp_pkg::METHOD_NOAUTH);
    end
    put(srp_pkg::SOCKS_VER);
    put(srp_pkg::REP_SUCCESS);
    put(8'($urandom));
    put(kind_byte);
  endfunction

  // A well-formed reply with random address, port and reserved byte.
  function automatic void put_good_reply(bit method_en);
    int len;
    case ($urandom_range(0, 2))
      0: begin
        put_header(method_en, srp_pkg::ATYP_IPV4);
        put_random(6);
      end
      1: begin
        put_header(method_en, srp_pkg::ATYP_DOMAIN);
        len = ($urandom_range(0, 19) == 0) ? 255 : $urandom_range(0, 12);
        put(8'(len));
        put_random(len + 2);
      end
      default: begin
        put_header(method_en, srp_pkg::ATYP_IPV6);
        put_random(18);
      end
    endcase
  endfunction

  // A reply that breaks off at one of the checks the parser makes.
  function automatic void put_broken_reply(bit method_en);
    logic [7:0] b;
    case ($urandom_range(0, 4))
      0: put(not_version());
      1: begin
        put(srp_pkg::SOCKS_VER);
        if (method_en) begin
          b = 8'($urandom);
          if (b == srp_pkg::METHOD_NOAUTH) b = 8'hFF;
          put(b);
        end else begin
          put(8'($urandom_range(1, 255)));
        end
      end
      2: begin
        if (method_en) begin
          put(srp_pkg::SOCKS_VER);
          put(srp_pkg::METHOD_NOAUTH);
        end
        put(not_version());
      end
      3: begin
        if (method_en) begin
          put(srp_pkg::SOCKS_VER);
          put(srp_pkg::METHOD_NOAUTH);
        end
        put(srp_pkg::SOCKS_VER);
        put(8'($urandom_range(1, 255)));
      end
      default: begin
        do b = 8'($urandom);
        while (b == srp_pkg::ATYP_IPV4 || b == srp_pkg::ATYP_DOMAIN ||
               b == srp_pkg::ATYP_IPV6);
        put_header(method_en, b);
      end
    endcase
  endfunction

  // Offers one byte and returns at the edge where it is transferred.
  task automatic push_byte(input logic [7:0] b);
    in_valid <= 1'b1;
    in_rx_byte <= b;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    board.note_byte(b);
    bytes_sent++;
  endtask

  task automatic wait_replies();
    while (board.awaited() != 0) @(posedge clk);
  endtask

  // Sends the planned bytes in bursts with random gaps. Halfway through, the sender
  // stops until every reply due so far has come out.
  task automatic send_plan(input bit with_pause);
    int burst;
    int gap;
    int half;
    int idx;
    half = plan.size() / 2;
    idx = 0;
    while (plan.size() != 0) begin
      burst = $urandom_range(1, 24);
      while (burst > 0 && plan.size() != 0) begin
        push_byte(plan.pop_front());
        burst--;
        idx++;
        if (with_pause && idx == half) begin
          in_valid <= 1'b0;
          wait_replies();
          @(posedge clk);
        end
      end
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap != 0 && plan.size() != 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    in_valid <= 1'b0;
  endtask

  // The enable may only change while nothing is in flight inside the block.
  task automatic settle_block();
    wait_replies();
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_method_phase(input logic v);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= v;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    board.method_en = v;
  endtask

  initial begin : stimulus
    logic phase_en[6];
    in_valid <= 1'b0;
    in_rx_byte <= 8'h00;
    cfg_wr_en <= 1'b0;
    cfg_wr_data <= 1'b0;
    rst_n <= 1'b0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed part with the reset enable: an all-ones IPv4 reply, a bad method version,
    // a rejected auth method and a bad header version.
    put_header(1'b1, srp_pkg::ATYP_IPV4);
    repeat (6) put(8'hFF);
    put(8'hFF);
    put(srp_pkg::SOCKS_VER); put(8'h01);
    put(srp_pkg::SOCKS_VER); put(srp_pkg::METHOD_NOAUTH); put(8'h06);
    send_plan(1'b0);
    settle_block();

    // Directed part without the method reply: a server error code of all ones, an
    // unknown address type and an empty domain followed by its port.
    write_method_phase(1'b0);
    put(srp_pkg::SOCKS_VER); put(8'hFF);
    put(srp_pkg::SOCKS_VER); put(srp_pkg::REP_SUCCESS); put(8'h00); put(8'hFF);
    put(srp_pkg::SOCKS_VER); put(srp_pkg::REP_SUCCESS); put(8'h00);
    put(srp_pkg::ATYP_DOMAIN); put(8'h00);
    put(8'h12); put(8'h34);
    send_plan(1'b0);
    settle_block();

    // Random phases, each under its own enable setting.
    phase_en = '{1'b1, 1'b0, 1'b0, 1'b1, 1'($urandom), 1'($urandom)};
    foreach (phase_en[p]) begin
      write_method_phase(phase_en[p]);
      while (plan.size() < PHASE_BYTES) begin
        case ($urandom_range(0, 9))
          7, 8: put_broken_reply(phase_en[p]);
          9: put_random($urandom_range(1, 3));
          default: put_good_reply(phase_en[p]);
        endcase
      end
      if (p == 2) hold_req = 1'b1;
      send_plan(1'b1);
      settle_block();
    end

    wait_replies();
    repeat (10) @(posedge clk);
    $display("Run covered %0d bytes and %0d checked replies (%0d complete, %0d errors),",
             bytes_sent, board.replies_checked, board.ok_replies,
             board.replies_checked - board.ok_replies);
    $display("with the method reply phase both on and off and one long receiver hold-off.");
    if (board.errors == 0 && board.awaited() == 0) begin
      $display("tb: PASS");
    end else begin
      $display("tb: FAIL");
    end
    $finish;
  end

endmodule

// File: filelist.f
sv/srp_pkg.sv
sv/srp_in_stage.sv
sv/srp_core.sv
sv/srp_out_stage.sv
sv/socks5_reply_parser.sv
test/tb.sv
